// ----- hdl/qoq_pkg.sv -----
// Package: shared status and command codes of the QoS ordered queue.
`default_nettype none
package qoq_pkg;
  typedef logic [1:0] status_t;
  localparam status_t StOk    = 2'd0;
  localparam status_t StFull  = 2'd1;
  localparam status_t StRange = 2'd2;
  localparam logic CmdPush = 1'b0;
  localparam logic CmdPop  = 1'b1;
endpackage
`default_nettype wire

// ----- hdl/qoq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module qoq_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- hdl/qos_ordered_queue.sv -----
// Top level: bounded message queue with FIFO or QoS-ordered insertion.
`default_nettype none
// One beat in, one beat out per command. Entries live in a single RAM
// ({qos, payload} per word, registered read). A sequencer walks the RAM one
// entry at a time: a push in priority mode scans from the head for the first
// entry of lower QoS, then shifts the tail up by one and writes the new entry.
// A pop reads the indexed entry and shifts the rest down. Scanned plus moved
// entries never exceed the fill count plus one. Refused commands (full, index
// out of range) go straight from idle to the result state. The result waits in
// an output register; the next command is taken once the sequencer is back at
// idle. No clearing pass after reset: only entries below the fill count are
// ever read.
module qos_ordered_queue #(
  parameter int DEPTH        = 16,
  parameter int PAYLOAD_BITS = 32,
  parameter int QOS_BITS     = 4
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,     // priority_mode
  input  wire logic s_axis_tvalid_i,
  output logic      s_axis_tready_o,
  // msg_qos, msg_payload, pop_index (4 bits), zero fill
  input  wire logic [((QOS_BITS+PAYLOAD_BITS+4+7)/8)*8-1:0] s_axis_tdata_i,
  input  wire logic s_axis_tuser_i,  // cmd
  output logic      m_axis_tvalid_o,
  input  wire logic m_axis_tready_i,
  // status (2), out_qos, out_payload, entry_count, zero fill
  output logic [((2+QOS_BITS+PAYLOAD_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata_o
);
  localparam int IDXW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH+1);
  localparam int CMPW = (CNTW > 4) ? CNTW : 4;
  localparam int MEMW = QOS_BITS + PAYLOAD_BITS;
  localparam int OUTW = 2 + QOS_BITS + PAYLOAD_BITS + CNTW;
  localparam int OUTB = ((OUTW + 7) / 8) * 8;

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SScanRd  = 4'd1;
  localparam logic [3:0] SScanCmp = 4'd2;
  localparam logic [3:0] SShRd    = 4'd3;
  localparam logic [3:0] SShWr    = 4'd4;
  localparam logic [3:0] SWrNew   = 4'd5;
  localparam logic [3:0] SPopRd   = 4'd6;
  localparam logic [3:0] SPopCap  = 4'd7;
  localparam logic [3:0] SPlRd    = 4'd8;
  localparam logic [3:0] SPlWr    = 4'd9;
  localparam logic [3:0] SDone    = 4'd10;

  logic [3:0]  state_q, state_d;
  logic        mode_q;
  logic [CNTW-1:0] fill_q, fill_d;
  logic [CNTW-1:0] j_q, j_d;      // walk pointer
  logic [CNTW-1:0] pos_q, pos_d;  // insert position
  logic [QOS_BITS-1:0]     qos_q, qos_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  qoq_pkg::status_t        rst_q, rst_d;   // result status
  logic [QOS_BITS-1:0]     rqos_q, rqos_d;
  logic [PAYLOAD_BITS-1:0] rpay_q, rpay_d;
  logic            ovalid_q, ovalid_d;
  logic [OUTW-1:0] odata_q, odata_d;

  logic            we;
  logic [IDXW-1:0] waddr, raddr;
  logic [MEMW-1:0] wdata, rdata;

  logic [QOS_BITS-1:0]     in_qos;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [3:0]              in_idx;
  logic [CNTW:0]           j_inc1, j_inc2;
  logic [CNTW-1:0]         j_dec;

  assign in_qos = s_axis_tdata_i[QOS_BITS-1:0];
  assign in_pay = s_axis_tdata_i[QOS_BITS+PAYLOAD_BITS-1:QOS_BITS];
  assign in_idx = s_axis_tdata_i[QOS_BITS+PAYLOAD_BITS+3:QOS_BITS+PAYLOAD_BITS];
  assign j_inc1 = {1'b0, j_q} + (CNTW+1)'(1);
  assign j_inc2 = {1'b0, j_q} + (CNTW+1)'(2);
  assign j_dec  = j_q - CNTW'(1);

  assign s_axis_tready_o = (state_q == SIdle);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = OUTB'(odata_q);

  qoq_ram #(.WIDTH(MEMW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    fill_d   = fill_q;
    j_d      = j_q;
    pos_d    = pos_q;
    qos_d    = qos_q;
    pay_d    = pay_q;
    rst_d    = rst_q;
    rqos_d   = rqos_q;
    rpay_d   = rpay_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    we       = 1'b0;
    waddr    = j_q[IDXW-1:0];
    wdata    = rdata;
    raddr    = j_q[IDXW-1:0];

    if (ovalid_q && m_axis_tready_i) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid_i) begin
          qos_d  = in_qos;
          pay_d  = in_pay;
          rqos_d = '0;
          rpay_d = '0;
          rst_d  = qoq_pkg::StOk;
          if (s_axis_tuser_i == qoq_pkg::CmdPush) begin
            if (fill_q == CNTW'(DEPTH)) begin
              rst_d   = qoq_pkg::StFull;
              state_d = SDone;
            end else if (mode_q && (fill_q != '0)) begin
              j_d     = '0;
              state_d = SScanRd;
            end else begin
              pos_d   = fill_q;
              j_d     = fill_q;
              state_d = SWrNew;
            end
          end else begin
            if (CMPW'(in_idx) >= CMPW'(fill_q)) begin
              rst_d   = qoq_pkg::StRange;
              state_d = SDone;
            end else begin
              j_d     = CNTW'(in_idx);
              state_d = SPopRd;
            end
          end
        end
      end
      SScanRd: state_d = SScanCmp;
      SScanCmp: begin
        if (rdata[MEMW-1:PAYLOAD_BITS] < qos_q) begin
          pos_d = j_q;
          j_d   = fill_q;
          state_d = SShRd;
        end else if (j_inc1 == {1'b0, fill_q}) begin
          pos_d   = fill_q;
          j_d     = fill_q;
          state_d = SWrNew;
        end else begin
          j_d     = j_inc1[CNTW-1:0];
          state_d = SScanRd;
        end
      end
      SShRd: begin
        raddr   = j_dec[IDXW-1:0];
        state_d = SShWr;
      end
      SShWr: begin
        we    = 1'b1;
        j_d   = j_dec;
        state_d = (j_dec == pos_q) ? SWrNew : SShRd;
      end
      SWrNew: begin
        we      = 1'b1;
        waddr   = pos_q[IDXW-1:0];
        wdata   = {qos_q, pay_q};
        fill_d  = fill_q + CNTW'(1);
        state_d = SDone;
      end
      SPopRd: state_d = SPopCap;
      SPopCap: begin
        rqos_d = rdata[MEMW-1:PAYLOAD_BITS];
        rpay_d = rdata[PAYLOAD_BITS-1:0];
        if (j_inc1 < {1'b0, fill_q}) begin
          state_d = SPlRd;
        end else begin
          fill_d  = fill_q - CNTW'(1);
          state_d = SDone;
        end
      end
      SPlRd: begin
        raddr   = j_inc1[IDXW-1:0];
        state_d = SPlWr;
      end
      SPlWr: begin
        we  = 1'b1;
        j_d = j_inc1[CNTW-1:0];
        if (j_inc2 >= {1'b0, fill_q}) begin
          fill_d  = fill_q - CNTW'(1);
          state_d = SDone;
        end else begin
          state_d = SPlRd;
        end
      end
      SDone: begin
        if (!ovalid_q || m_axis_tready_i) begin
          ovalid_d = 1'b1;
          odata_d  = {fill_q, rpay_q, rqos_q, rst_q};
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      fill_q   <= '0;
      mode_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    j_q     <= j_d;
    pos_q   <= pos_d;
    qos_q   <= qos_d;
    pay_q   <= pay_d;
    rst_q   <= rst_d;
    rqos_q  <= rqos_d;
    rpay_q  <= rpay_d;
    odata_q <= odata_d;
  end

`ifndef ASSERT_OFF
  // fill count never exceeds capacity
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNTW'(DEPTH)) else $error("fill count above depth");
  // RAM written only from write states
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == SShWr || state_q == SWrNew || state_q == SPlWr))
    else $error("stray RAM write");
  // fill count changes only at the end of a command
  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q != $past(fill_q)) |-> (state_q == SDone))
    else $error("fill changed mid command");
`endif
endmodule
`default_nettype wire
